// File: design/lpfr_pkg.sv
// ----------------------------------------------------------------------------
// lpfr_pkg
// shared types and constants for the lru page frame replacement block
// ----------------------------------------------------------------------------
package lpfr_pkg;

    localparam int SLOT_W = 3;   // width of the reported frame index
    localparam int MISS_W = 32;  // width of the saturating miss count

    // controller to datapath
    typedef struct packed {
        logic start;   // capture the page and clear the scan flags
        logic scan;    // look at one frame and step the scan index
        logic update;  // apply the replacement and load the result register
    } lpfr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;  // scan index sits on the last frame
    } lpfr_status_t;

endpackage

// File: design/lpfr_ctrl.sv
// ----------------------------------------------------------------------------
// lpfr_ctrl
// sequencer: accept, scan every frame, update, then hand over the result
// ----------------------------------------------------------------------------
module lpfr_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  lpfr_pkg::lpfr_status_t sts,
    output lpfr_pkg::lpfr_cmd_t   cmd
);
    import lpfr_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // hold here while the previous result still waits
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.update)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: design/lpfr_datapath.sv
// ----------------------------------------------------------------------------
// lpfr_datapath
// page memory, frame valid bits, recency ranks, scan registers, miss counter
// and the result register
// ----------------------------------------------------------------------------
module lpfr_datapath
#(
    parameter int FRAME_COUNT = 8,
    parameter int PAGE_BITS   = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lpfr_pkg::lpfr_cmd_t         cmd,
    output lpfr_pkg::lpfr_status_t      sts,
    input  logic [PAGE_BITS-1:0]        page_in,
    output logic                        hit_out,
    output logic [lpfr_pkg::SLOT_W-1:0] frame_slot_out,
    output logic                        evicted_valid_out,
    output logic [PAGE_BITS-1:0]        evicted_page_out,
    output logic [lpfr_pkg::MISS_W-1:0] miss_total_out
);
    import lpfr_pkg::*;

    localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);
    // rank given to a frame being filled: older than every valid frame
    localparam logic [IDX_W:0] NEW_RANK = (IDX_W + 1)'(FRAME_COUNT);

    // page store, one read port for the scan and one write port
    logic [PAGE_BITS-1:0] page_mem [FRAME_COUNT];
    logic [PAGE_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W:0]       idx_plus;
    logic                 mem_we;

    logic [FRAME_COUNT-1:0] valid_reg;
    logic [IDX_W-1:0]       rank_reg [FRAME_COUNT];
    logic [MISS_W-1:0]      miss_reg;
    logic [IDX_W-1:0]       idx_reg;

    // scan results
    logic                 found_reg;
    logic [IDX_W-1:0]     hit_slot_reg;
    logic [IDX_W-1:0]     hit_rank_reg;
    logic                 have_victim_reg;
    logic [IDX_W-1:0]     victim_slot_reg;
    logic [IDX_W-1:0]     victim_rank_reg;
    logic [PAGE_BITS-1:0] victim_page_reg;
    logic                 have_empty_reg;
    logic [IDX_W-1:0]     empty_slot_reg;
    logic [PAGE_BITS-1:0] page_reg;

    // current frame under the scan
    logic             cur_valid;
    logic [IDX_W-1:0] cur_rank;
    logic             take_hit;
    logic             take_victim;
    logic             take_empty;

    // update decision
    logic             miss;
    logic             evict;
    logic [IDX_W-1:0] slot;
    logic [IDX_W:0]   old_rank;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    assign sts.scan_last = (idx_reg == LAST_IDX);

    assign cur_valid   = valid_reg[idx_reg];
    assign cur_rank    = rank_reg[idx_reg];
    assign take_hit    = cmd.scan && cur_valid && !found_reg && (rd_data_reg == page_reg);
    assign take_victim = cmd.scan && cur_valid && (!have_victim_reg || cur_rank > victim_rank_reg);
    assign take_empty  = cmd.scan && !cur_valid && !have_empty_reg;

    // read one ahead so that the data for idx_reg is ready in its cycle
    assign idx_plus = {1'b0, idx_reg} + 1'b1;
    assign rd_addr  = (cmd.scan && !sts.scan_last) ? idx_plus[IDX_W-1:0] : '0;

    assign miss  = !found_reg;
    assign evict = miss && !have_empty_reg;

    always_comb
    begin
        if (found_reg)
        begin
            slot     = hit_slot_reg;
            old_rank = {1'b0, hit_rank_reg};
        end
        else if (have_empty_reg)
        begin
            slot     = empty_slot_reg;
            old_rank = NEW_RANK;
        end
        else
        begin
            slot     = victim_slot_reg;
            old_rank = {1'b0, victim_rank_reg};
        end
    end

    assign mem_we   = cmd.update && miss;
    assign slot_ext = {{SLOT_W{1'b0}}, slot};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_mem[slot] <= page_reg;
        end
        rd_data_reg <= page_mem[rd_addr];
    end

    // control state: scan index, flags, valid bits, ranks, miss counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            found_reg       <= 1'b0;
            have_victim_reg <= 1'b0;
            have_empty_reg  <= 1'b0;
            valid_reg       <= '0;
            miss_reg        <= '0;
            for (int i = 0; i < FRAME_COUNT; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.start)
            begin
                idx_reg         <= '0;
                found_reg       <= 1'b0;
                have_victim_reg <= 1'b0;
                have_empty_reg  <= 1'b0;
            end
            else if (cmd.scan)
            begin
                if (!sts.scan_last)
                begin
                    idx_reg <= idx_plus[IDX_W-1:0];
                end
                if (take_hit)
                begin
                    found_reg <= 1'b1;
                end
                if (take_victim)
                begin
                    have_victim_reg <= 1'b1;
                end
                if (take_empty)
                begin
                    have_empty_reg <= 1'b1;
                end
            end
            else if (cmd.update)
            begin
                idx_reg <= '0;
                for (int i = 0; i < FRAME_COUNT; i++)
                begin
                    if (IDX_W'(i) == slot)
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (valid_reg[i] && ({1'b0, rank_reg[i]} < old_rank))
                    begin
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                end
                if (miss)
                begin
                    valid_reg[slot] <= 1'b1;
                    if (miss_reg != '1)
                    begin
                        miss_reg <= miss_reg + 1'b1;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            page_reg <= page_in;
        end
        if (take_hit)
        begin
            hit_slot_reg <= idx_reg;
            hit_rank_reg <= cur_rank;
        end
        if (take_victim)
        begin
            victim_slot_reg <= idx_reg;
            victim_rank_reg <= cur_rank;
            victim_page_reg <= rd_data_reg;
        end
        if (take_empty)
        begin
            empty_slot_reg <= idx_reg;
        end
        if (cmd.update)
        begin
            hit_out           <= found_reg;
            frame_slot_out    <= slot_ext[SLOT_W-1:0];
            evicted_valid_out <= evict;
            evicted_page_out  <= evict ? victim_page_reg : '0;
            // counter value after this access
            miss_total_out    <= (miss && miss_reg != '1) ? miss_reg + 1'b1 : miss_reg;
        end
    end

endmodule

// File: design/lru_page_frame_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_frame_replacement
// looks up one page reference per transaction in a set of page frames and
// loads it on a miss, replacing the least recently used frame when full
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         page reference
//  m_axis    out        hit, frame, evicted page, miss count
//
//  each reference passes through an accept state, a scan that reads the frames
//  one by one through the single read port of the page memory, and an update
//  state for ranks, valid bits and the result register.
//  reset empties all frames and clears ranks and the miss count at once.
//  a pending result holds in the output register; the next reference is
//  accepted and scanned, and only its update waits for m_axis_tready.
// ----------------------------------------------------------------------------
module lru_page_frame_replacement
#(
    parameter int FRAME_COUNT = 8,
    parameter int PAGE_BITS   = 16,
    localparam int IN_W     = ((PAGE_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 1 + lpfr_pkg::SLOT_W + 1 + PAGE_BITS + lpfr_pkg::MISS_W,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // page_number
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // hit, frame_slot, evicted_valid,
                                             // evicted_page, miss_total
);
    import lpfr_pkg::*;

    lpfr_cmd_t    cmd;
    lpfr_status_t sts;

    logic                 hit;
    logic [SLOT_W-1:0]    frame_slot;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [MISS_W-1:0]    miss_total;
    logic [OUT_BITS-1:0]  result;

    lpfr_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    lpfr_datapath
    #(
        .FRAME_COUNT (FRAME_COUNT),
        .PAGE_BITS   (PAGE_BITS)
    )
    u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .page_in           (s_axis_tdata[PAGE_BITS-1:0]),
        .hit_out           (hit),
        .frame_slot_out    (frame_slot),
        .evicted_valid_out (evicted_valid),
        .evicted_page_out  (evicted_page),
        .miss_total_out    (miss_total)
    );

    assign result       = {miss_total, evicted_page, evicted_valid, frame_slot, hit};
    assign m_axis_tdata = OUT_W'(result);

endmodule

// File: tb/lru_page_frame_replacement_tb.sv
// ----------------------------------------------------------------------------
// lru_page_frame_replacement_tb
// self-checking bench for the lru page frame replacement block: page references
// go in on s_axis, and a predictor that keeps its own frames, recency ranks and
// miss count checks every result on m_axis field by field, with random idling
// on both channels
// ----------------------------------------------------------------------------
module lru_page_frame_replacement_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES           = 8;
    localparam int PAGE_W           = 16;
    localparam int OUT_W            = 56;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 40;

    // packed as on m_axis_tdata: hit at bit 0, miss_total at the top
    typedef struct packed {
        logic [lpfr_pkg::MISS_W-1:0] miss_total;
        logic [PAGE_W-1:0]           evicted_page;
        logic                        evicted_valid;
        logic [lpfr_pkg::SLOT_W-1:0] frame_slot;
        logic                        hit;
    } lookup_result_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [PAGE_W-1:0] s_axis_tdata;   // page_number
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;   // hit, frame_slot, evicted_valid,
                                       // evicted_page, miss_total

    // predictor state
    logic [PAGE_W-1:0]           resident_page [FRAMES];
    bit                          resident      [FRAMES];
    int unsigned                 age_rank      [FRAMES];
    logic [lpfr_pkg::MISS_W-1:0] miss_count_model;

    lookup_result_t expected_lookups[$];

    int  mismatch_count;
    int  pages_sent;
    int  results_checked;
    int  hits_seen;
    int  evictions_seen;
    bit  sender_steady;
    bit  receiver_steady;
    bit  long_hold_pending;

    lru_page_frame_replacement #(
        .FRAME_COUNT (FRAMES),
        .PAGE_BITS   (PAGE_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // valid frames younger than old_rank age by one, slot becomes youngest
    function automatic void make_most_recent(input int slot, input int unsigned old_rank);
        for (int i = 0; i < FRAMES; i++)
        begin
            if (i != slot && resident[i] && age_rank[i] < old_rank)
                age_rank[i]++;
        end
        age_rank[slot] = 0;
    endfunction

    function automatic lookup_result_t lookup_page(input logic [PAGE_W-1:0] page);
        lookup_result_t res;
        bit             found;
        bit             have_empty;
        bit             have_victim;
        int             slot;
        int             empty_slot;
        int             victim;
        int unsigned    victim_rank;
        found       = 1'b0;
        have_empty  = 1'b0;
        have_victim = 1'b0;
        slot        = 0;
        empty_slot  = 0;
        victim      = 0;
        victim_rank = 0;
        res         = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (resident[i])
            begin
                if (!found && resident_page[i] == page)
                begin
                    found = 1'b1;
                    slot  = i;
                end
                if (!have_victim || age_rank[i] > victim_rank)
                begin
                    have_victim = 1'b1;
                    victim      = i;
                    victim_rank = age_rank[i];
                end
            end
            else if (!have_empty)
            begin
                have_empty = 1'b1;
                empty_slot = i;
            end
        end
        if (found)
        begin
            res.hit = 1'b1;
            make_most_recent(slot, age_rank[slot]);
        end
        else
        begin
            if (miss_count_model != '1)
                miss_count_model++;
            if (have_empty)
            begin
                slot                = empty_slot;
                resident[slot]      = 1'b1;
                resident_page[slot] = page;
                // a fresh frame is older than every valid one
                make_most_recent(slot, FRAMES);
            end
            else
            begin
                slot                = victim;
                res.evicted_valid   = 1'b1;
                res.evicted_page    = resident_page[slot];
                resident_page[slot] = page;
                make_most_recent(slot, victim_rank);
            end
        end
        res.frame_slot = slot[lpfr_pkg::SLOT_W-1:0];
        res.miss_total = miss_count_model;
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_length(input int min_len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return min_len;
        if (r < 92)
            return $urandom_range(min_len + 1, 4);
        return $urandom_range(12, 40);
    endfunction

    task automatic send_page(input logic [PAGE_W-1:0] page);
        int gap;
        gap = sender_steady ? 0 : idle_length(0);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= page;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_lookups.push_back(lookup_page(page));
        pages_sent++;
    endtask

    // all frames empty after reset: each miss takes the lowest empty frame
    task automatic test_fill_empty_frames();
        logic [PAGE_W-1:0] fill_pages [FRAMES];
        fill_pages = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                       16'h5555, 16'hAAAA, 16'h1234, 16'h00FF};
        foreach (fill_pages[i])
            send_page(fill_pages[i]);
    endtask

    // hits on first, last and repeated frames reorder recency
    task automatic test_hits_promote();
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'h00FF);
        send_page(16'hFFFF);
    endtask

    // full set: misses replace the least recently used frame
    task automatic test_lru_eviction();
        send_page(16'h7777);
        send_page(16'h0001);
        send_page(16'h7777);
        send_page(16'hFEDC);
    endtask

    // working sets of random size around the frame count, plus random noise
    task automatic test_working_set_random(input int count);
        logic [PAGE_W-1:0] pool [12];
        int                pool_size;
        logic [PAGE_W-1:0] page;
        pool_size = 1;
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
            begin
                pool_size = $urandom_range(4, 12);
                for (int k = 0; k < pool_size; k++)
                    pool[k] = PAGE_W'($urandom());
            end
            if ($urandom_range(0, 99) < 80)
                page = pool[$urandom_range(0, pool_size - 1)];
            else
                page = PAGE_W'($urandom());
            send_page(page);
        end
    endtask

    // output held off long enough that the block stops taking input
    task automatic test_output_backpressure(input int count);
        long_hold_pending = 1'b1;
        sender_steady     = 1'b1;
        for (int n = 0; n < count; n++)
            send_page(PAGE_W'($urandom_range(0, 15)));
        sender_steady = 1'b0;
    endtask

    task automatic test_back_to_back(input int count);
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        for (int n = 0; n < count; n++)
            send_page($urandom_range(0, 1) ? PAGE_W'($urandom_range(0, 11))
                                           : PAGE_W'($urandom()));
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    initial
    begin : output_ready_driver
        int stall;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_pending)
            begin
                m_axis_tready <= 1'b0;
                stall = 0;
                while (stall < LONG_HOLD_CYCLES)
                begin
                    @(posedge clk);
                    stall++;
                end
                long_hold_pending = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (!receiver_steady && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (idle_length(1)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        lookup_result_t got;
        lookup_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[$bits(lookup_result_t)-1:0];
            if (expected_lookups.size() == 0)
            begin
                $error("result transaction with nothing expected: tdata %0h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_lookups.pop_front();
                results_checked++;
                if (want.hit)
                    hits_seen++;
                if (want.evicted_valid)
                    evictions_seen++;
                if (got.hit !== want.hit)
                begin
                    $error("hit: expected %0h, got %0h", want.hit, got.hit);
                    mismatch_count++;
                end
                if (got.frame_slot !== want.frame_slot)
                begin
                    $error("frame_slot: expected %0h, got %0h", want.frame_slot, got.frame_slot);
                    mismatch_count++;
                end
                if (got.evicted_valid !== want.evicted_valid)
                begin
                    $error("evicted_valid: expected %0h, got %0h",
                           want.evicted_valid, got.evicted_valid);
                    mismatch_count++;
                end
                if (got.evicted_page !== want.evicted_page)
                begin
                    $error("evicted_page: expected %0h, got %0h",
                           want.evicted_page, got.evicted_page);
                    mismatch_count++;
                end
                if (got.miss_total !== want.miss_total)
                begin
                    $error("miss_total: expected %0h, got %0h", want.miss_total, got.miss_total);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        m_axis_tready     = 1'b0;
        sender_steady     = 1'b0;
        receiver_steady   = 1'b0;
        long_hold_pending = 1'b0;
        mismatch_count    = 0;
        pages_sent        = 0;
        results_checked   = 0;
        hits_seen         = 0;
        evictions_seen    = 0;
        miss_count_model  = '0;
        foreach (resident[i])
        begin
            resident[i]      = 1'b0;
            resident_page[i] = '0;
            age_rank[i]      = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_empty_frames();
        test_hits_promote();
        test_lru_eviction();
        test_working_set_random(780);
        test_output_backpressure(30);
        test_back_to_back(120);

        s_axis_tvalid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d page references sent, %0d results checked (%0d hits, %0d evictions)",
                 pages_sent, results_checked, hits_seen, evictions_seen);
        $display("covered empty-frame fill, hit promotion, lru eviction, random working sets,");
        $display("a long output stall and a back-to-back stretch");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
